// ----- design/mbtcp_pkg.sv -----
// mbtcp_pkg: shared types and constants for the modbus tcp function 03 slave
// holds the sequencer state type, reply constants and configuration indexes
// no dependencies
`default_nettype none

package mbtcp_pkg;

	// defaults for the top level parameters
	localparam int TABLE_DEPTH_DEF = 256;
	localparam int MAX_READ_DEF    = 123;

	// request header kept from the frame
	localparam logic [3:0] HDR_LEN      = 4'd12;
	localparam logic [3:0] HDR_FULL_M1  = 4'd11;
	// last header byte position of a reply (bytes 0..8)
	localparam logic [3:0] REPLY_HDR_END = 4'd8;

	// exception codes and fixed exception length field
	localparam logic [7:0]  EXC_RANGE    = 8'h02;
	localparam logic [7:0]  EXC_VALUE    = 8'h03;
	localparam logic [15:0] EXC_LEN      = 16'h0003;
	localparam logic [7:0]  FUNC_EXC_BIT = 8'h80;

	// input item kinds
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_TABLE = 1'b1;

	// configuration register indexes
	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WMOD,
		ST_CHK_LO,
		ST_CHK_SUM,
		ST_CHK_HI,
		ST_LEN,
		ST_HDR,
		ST_RD,
		ST_HI,
		ST_LO,
		ST_BEAT
	} state_t;

endpackage

`default_nettype wire

// ----- design/modbus_tcp_read_holding_regs.sv -----
// modbus_tcp_read_holding_regs: a table write folds reg_index below TABLE_DEPTH by repeated
// subtraction on the shared add/subtract unit in ST_WMOD, then writes the table; the last
// byte of a frame with a full header starts checks in ST_CHK_LO, ST_CHK_SUM, ST_CHK_HI, ST_LEN,
// then ST_HDR header bytes, ST_RD/ST_HI/ST_LO per word (read, high, low byte), ST_BEAT per beat
// throughput: one transaction at a time, in_ready is low while a request or write is worked on
// reset: arst_n clears control, config and byte count; header and table stay undefined
`default_nettype none

module modbus_tcp_read_holding_regs #(
	parameter int TABLE_DEPTH = mbtcp_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_READ    = mbtcp_pkg::MAX_READ_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	// input items
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        frame_last,
	input  wire logic [7:0]  reg_index,
	input  wire logic [15:0] reg_value,
	// reply beats
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      out_data,
	output logic [3:0]       out_bytes,
	output logic             out_last,
	output logic             out_exception
);

	// table address width, index register width, word count width
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IW = (AW > 8) ? AW : 8;
	localparam int QW = $clog2(MAX_READ + 1);
	localparam logic [16:0] DEPTH_W    = 17'(TABLE_DEPTH);
	localparam logic [15:0] MAX_READ_W = 16'(MAX_READ);

	mbtcp_pkg::state_t state_q, state_d, resume_q;

	// configuration registers
	logic [15:0] base_q;
	logic [8:0]  count_q;

	// request header store and byte count
	logic [7:0] hdr_q [mbtcp_pkg::HDR_LEN];
	logic [3:0] byte_cnt_q;

	// pending table write
	logic [IW-1:0] widx_q;
	logic [15:0]   wval_q;

	// register table, one write and one registered read port
	logic [15:0] table_q [TABLE_DEPTH];
	logic [15:0] rd_data_q;
	logic        rd_en;

	// check results
	logic [15:0] diff_q;
	logic        lt_q;
	logic [16:0] sum_q;
	logic        over_q;

	// reply state
	logic [15:0]   len_q;
	logic [7:0]    byte8_q;
	logic          exc_q;
	logic [QW-1:0] words_left_q;
	logic [AW-1:0] addr_q;
	logic [3:0]    pos_q;
	logic [3:0]    fill_q;
	logic          last_q;
	logic [63:0]   beat_q;

	// shared add/subtract unit
	logic [17:0] alu_a, alu_b, alu_res;
	logic        alu_sub;
	logic        alu_neg;

	logic [15:0] start_w, qty_w;
	logic [16:0] cnt_w;
	logic        range_bad;
	logic        in_acc, frame_acc, table_acc;
	logic        place_en;
	logic [7:0]  place_byte;
	logic        full_w, hdr_end_w, hdr_final_w, word_end_w;
	logic [7:0]  hdr_sel;

	// request fields, big-endian
	assign start_w = {hdr_q[8], hdr_q[9]};
	assign qty_w   = {hdr_q[10], hdr_q[11]};
	// count above table depth acts as the depth
	assign cnt_w   = ({8'b0, count_q} > DEPTH_W) ? DEPTH_W : {8'b0, count_q};
	assign range_bad = lt_q | over_q | (qty_w > MAX_READ_W);

	assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + {17'b0, alu_sub};
	assign alu_neg = alu_res[17];

	assign in_acc    = in_valid & in_ready;
	assign frame_acc = in_acc & (kind == mbtcp_pkg::KIND_FRAME);
	assign table_acc = in_acc & (kind == mbtcp_pkg::KIND_TABLE);

	// beat assembly conditions
	assign full_w      = (fill_q[2:0] == 3'd7);
	assign hdr_end_w   = (pos_q == mbtcp_pkg::REPLY_HDR_END);
	assign hdr_final_w = hdr_end_w & exc_q;
	assign word_end_w  = (words_left_q == '0);

	// reply header byte at position pos_q
	always_comb begin
		case (pos_q)
			4'd0:    hdr_sel = hdr_q[0];
			4'd1:    hdr_sel = hdr_q[1];
			4'd2:    hdr_sel = hdr_q[2];
			4'd3:    hdr_sel = hdr_q[3];
			4'd4:    hdr_sel = len_q[15:8];
			4'd5:    hdr_sel = len_q[7:0];
			4'd6:    hdr_sel = hdr_q[6];
			4'd7:    hdr_sel = hdr_q[7] ^ (exc_q ? mbtcp_pkg::FUNC_EXC_BIT : 8'h00);
			4'd8:    hdr_sel = byte8_q;
			default: hdr_sel = 8'h00;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mbtcp_pkg::ST_IDLE: begin
				if (table_acc) begin
					state_d = mbtcp_pkg::ST_WMOD;
				end else if (frame_acc && frame_last && byte_cnt_q >= mbtcp_pkg::HDR_FULL_M1) begin
					state_d = mbtcp_pkg::ST_CHK_LO;
				end
			end
			mbtcp_pkg::ST_WMOD: begin
				// index below depth: the write lands this cycle
				if (alu_neg) state_d = mbtcp_pkg::ST_IDLE;
			end
			mbtcp_pkg::ST_CHK_LO:  state_d = mbtcp_pkg::ST_CHK_SUM;
			mbtcp_pkg::ST_CHK_SUM: state_d = mbtcp_pkg::ST_CHK_HI;
			mbtcp_pkg::ST_CHK_HI:  state_d = mbtcp_pkg::ST_LEN;
			mbtcp_pkg::ST_LEN:     state_d = mbtcp_pkg::ST_HDR;
			mbtcp_pkg::ST_HDR: begin
				if (full_w || hdr_final_w) state_d = mbtcp_pkg::ST_BEAT;
				else if (hdr_end_w)        state_d = mbtcp_pkg::ST_RD;
			end
			mbtcp_pkg::ST_RD: state_d = mbtcp_pkg::ST_HI;
			mbtcp_pkg::ST_HI: state_d = full_w ? mbtcp_pkg::ST_BEAT : mbtcp_pkg::ST_LO;
			mbtcp_pkg::ST_LO: begin
				state_d = (full_w || word_end_w) ? mbtcp_pkg::ST_BEAT : mbtcp_pkg::ST_RD;
			end
			mbtcp_pkg::ST_BEAT: begin
				if (out_ready) state_d = last_q ? mbtcp_pkg::ST_IDLE : resume_q;
			end
			default: state_d = mbtcp_pkg::ST_IDLE;
		endcase
	end

	// outputs and shared unit operands
	always_comb begin
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		rd_en      = 1'b0;
		place_en   = 1'b0;
		place_byte = 8'h00;
		alu_a      = '0;
		alu_b      = '0;
		alu_sub    = 1'b0;
		unique case (state_q)
			mbtcp_pkg::ST_IDLE: in_ready = 1'b1;
			mbtcp_pkg::ST_WMOD: begin
				// fold the index into the table depth
				alu_a   = 18'(widx_q);
				alu_b   = {1'b0, DEPTH_W};
				alu_sub = 1'b1;
			end
			mbtcp_pkg::ST_CHK_LO: begin
				// start - base, negative means start below base
				alu_a   = {2'b0, start_w};
				alu_b   = {2'b0, base_q};
				alu_sub = 1'b1;
			end
			mbtcp_pkg::ST_CHK_SUM: begin
				alu_a = {2'b0, diff_q};
				alu_b = {2'b0, qty_w};
			end
			mbtcp_pkg::ST_CHK_HI: begin
				// count - (offset + quantity), negative means past the end
				alu_a   = {1'b0, cnt_w};
				alu_b   = {1'b0, sum_q};
				alu_sub = 1'b1;
			end
			mbtcp_pkg::ST_LEN: begin
				// 3 + 2 * quantity
				alu_a = {1'b0, qty_w, 1'b0};
				alu_b = 18'd3;
			end
			mbtcp_pkg::ST_HDR: begin
				place_en   = 1'b1;
				place_byte = hdr_sel;
			end
			mbtcp_pkg::ST_RD: begin
				rd_en   = 1'b1;
				alu_a   = 18'(words_left_q);
				alu_b   = 18'd1;
				alu_sub = 1'b1;
			end
			mbtcp_pkg::ST_HI: begin
				place_en   = 1'b1;
				place_byte = rd_data_q[15:8];
			end
			mbtcp_pkg::ST_LO: begin
				place_en   = 1'b1;
				place_byte = rd_data_q[7:0];
			end
			mbtcp_pkg::ST_BEAT: out_valid = 1'b1;
			default: ;
		endcase
	end

	assign cfg_ready     = 1'b1;
	assign out_data      = beat_q;
	assign out_bytes     = fill_q;
	assign out_last      = last_q;
	assign out_exception = exc_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mbtcp_pkg::ST_IDLE;
			resume_q     <= mbtcp_pkg::ST_IDLE;
			base_q       <= '0;
			count_q      <= '0;
			byte_cnt_q   <= '0;
			fill_q       <= '0;
			pos_q        <= '0;
			last_q       <= 1'b0;
			exc_q        <= 1'b0;
			words_left_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mbtcp_pkg::CFG_BASE) base_q <= cfg_data;
				else                                  count_q <= cfg_data[8:0];
			end
			// frame byte count saturates at the header length, frame end clears it
			if (frame_acc) begin
				if (frame_last)                           byte_cnt_q <= '0;
				else if (byte_cnt_q < mbtcp_pkg::HDR_LEN) byte_cnt_q <= byte_cnt_q + 4'd1;
			end
			case (state_q)
				mbtcp_pkg::ST_LEN: begin
					exc_q        <= range_bad | (qty_w == 16'd0);
					words_left_q <= qty_w[QW-1:0];
					pos_q        <= '0;
					fill_q       <= '0;
					last_q       <= 1'b0;
				end
				mbtcp_pkg::ST_HDR: begin
					fill_q <= fill_q + 4'd1;
					pos_q  <= pos_q + 4'd1;
					last_q <= hdr_final_w;
					resume_q <= hdr_end_w ? mbtcp_pkg::ST_RD : mbtcp_pkg::ST_HDR;
				end
				mbtcp_pkg::ST_RD: words_left_q <= alu_res[QW-1:0];
				mbtcp_pkg::ST_HI: begin
					fill_q   <= fill_q + 4'd1;
					resume_q <= mbtcp_pkg::ST_LO;
				end
				mbtcp_pkg::ST_LO: begin
					fill_q   <= fill_q + 4'd1;
					last_q   <= word_end_w;
					resume_q <= mbtcp_pkg::ST_RD;
				end
				mbtcp_pkg::ST_BEAT: begin
					if (out_ready) fill_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (frame_acc && byte_cnt_q < mbtcp_pkg::HDR_LEN) begin
			hdr_q[byte_cnt_q] <= frame_byte;
		end
		if (table_acc) begin
			widx_q <= IW'(reg_index);
			wval_q <= reg_value;
		end
		case (state_q)
			mbtcp_pkg::ST_WMOD: begin
				if (!alu_neg) widx_q <= alu_res[IW-1:0];
			end
			mbtcp_pkg::ST_CHK_LO: begin
				diff_q <= alu_res[15:0];
				lt_q   <= alu_neg;
			end
			mbtcp_pkg::ST_CHK_SUM: sum_q  <= alu_res[16:0];
			mbtcp_pkg::ST_CHK_HI:  over_q <= alu_neg;
			mbtcp_pkg::ST_LEN: begin
				// exception replies carry a fixed length and the code in place of byte count
				if (range_bad || qty_w == 16'd0) begin
					len_q   <= mbtcp_pkg::EXC_LEN;
					byte8_q <= range_bad ? mbtcp_pkg::EXC_RANGE : mbtcp_pkg::EXC_VALUE;
				end else begin
					len_q   <= alu_res[15:0];
					byte8_q <= {qty_w[6:0], 1'b0};
				end
				addr_q <= diff_q[AW-1:0];
				beat_q <= '0;
			end
			mbtcp_pkg::ST_RD: addr_q <= addr_q + AW'(1);
			mbtcp_pkg::ST_BEAT: begin
				if (out_ready) beat_q <= '0;
			end
			default: ;
		endcase
		// first byte of a beat lands in the top bits
		if (place_en) begin
			beat_q[{~fill_q[2:0], 3'b000} +: 8] <= place_byte;
		end
	end

	// register table
	always_ff @(posedge clk) begin
		if (state_q == mbtcp_pkg::ST_WMOD && alu_neg) begin
			table_q[widx_q[AW-1:0]] <= wval_q;
		end
		if (rd_en) begin
			rd_data_q <= table_q[addr_q];
		end
	end

endmodule

`default_nettype wire

// ----- design/mbtcp_checker.sv -----
// mbtcp_checker: port-level checks on the modbus tcp function 03 slave
// depends on the top level modbus_tcp_read_holding_regs, attached by bind
`default_nettype none

module mbtcp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] out_data,
	input wire logic [3:0]  out_bytes,
	input wire logic        out_last
);

	// a beat carries one to eight bytes
	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_bytes != 4'd0) && (out_bytes <= 4'd8))
		else $error("beat byte count out of range");

	// only the final beat of a reply may be short
	a_full_beats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_bytes == 4'd8)
		else $error("short beat before the end of a reply");

	// an accepted input transaction never shows a reply beat in the next cycle
	a_no_quick_reply: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("reply beat right after an input transaction");

	// a stalled beat holds its data
	a_beat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled beat changed");

endmodule

bind modbus_tcp_read_holding_regs mbtcp_checker u_mbtcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.out_bytes (out_bytes),
	.out_last  (out_last)
);

`default_nettype wire
